[rtl/core/mdm_pkg.sv]
// ----------------------------------------------------------------------------
// MDIO management master package
// Request codes, register map, frame layout constants and shared types.
// ----------------------------------------------------------------------------
package mdm_pkg;

    // Request selector carried by every input request.
    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_READ  = 2'd1,
        REQ_WRITE = 2'd2,
        REQ_SPARE = 2'd3
    } req_type_t;

    // Configuration register map (register index, byte address is 4 * index).
    localparam int unsigned REG_PREAMBLE_BITS = 0;
    localparam int unsigned CFG_ADDR_W        = 2;
    localparam int unsigned CFG_DATA_W        = 32;

    localparam int unsigned PREAMBLE_W        = 6;
    localparam logic [PREAMBLE_W-1:0] PREAMBLE_RESET = 6'd32;
    localparam logic [PREAMBLE_W-1:0] PREAMBLE_MAX   = 6'd32;

    localparam int unsigned POS_W  = 7;
    localparam int unsigned DATA_W = 16;
    localparam int unsigned ADDR_W = 5;

    // Frame offsets counted from the end of the preamble.
    localparam logic [POS_W-1:0] REL_START0  = 7'd0;
    localparam logic [POS_W-1:0] REL_START1  = 7'd1;
    localparam logic [POS_W-1:0] REL_OP0     = 7'd2;
    localparam logic [POS_W-1:0] REL_OP1     = 7'd3;
    localparam logic [POS_W-1:0] REL_PHY     = 7'd4;
    localparam logic [POS_W-1:0] REL_PHY_END = 7'd8;
    localparam logic [POS_W-1:0] REL_REG     = 7'd9;
    localparam logic [POS_W-1:0] REL_REG_END = 7'd13;
    localparam logic [POS_W-1:0] REL_TA0     = 7'd14;
    localparam logic [POS_W-1:0] REL_DATA    = 7'd16;
    localparam logic [POS_W-1:0] REL_DATA_END = 7'd31;
    localparam logic [POS_W-1:0] REL_TAIL    = 7'd32;

    // Per-bit control handed from the bit generator to the frame sequencer.
    typedef struct packed {
        logic line_out;
        logic line_drive;
        logic sample;
        logic done;
    } bit_ctl_t;

endpackage

[rtl/core/mdm_req_if.sv]
// ----------------------------------------------------------------------------
// MDIO master request channel
// Valid/ready channel carrying ticks and read/write requests.
// ----------------------------------------------------------------------------
interface mdm_req_if;
    import mdm_pkg::*;

    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [4:0]  phy_addr;
    logic [4:0]  reg_addr;
    logic [15:0] write_value;
    logic        line_in;

    modport source (
        output valid,
        input  ready,
        output req_type,
        output phy_addr,
        output reg_addr,
        output write_value,
        output line_in
    );

    modport sink (
        input  valid,
        output ready,
        input  req_type,
        input  phy_addr,
        input  reg_addr,
        input  write_value,
        input  line_in
    );

endinterface

[rtl/core/mdm_res_if.sv]
// ----------------------------------------------------------------------------
// MDIO master result channel
// Valid/ready channel carrying one result per accepted request.
// ----------------------------------------------------------------------------
interface mdm_res_if;
    import mdm_pkg::*;

    logic        valid;
    logic        ready;
    logic        line_out;
    logic        line_drive;
    logic        busy_res;
    logic        frame_done;
    logic [15:0] read_value;
    logic        request_dropped;

    modport source (
        output valid,
        input  ready,
        output line_out,
        output line_drive,
        output busy_res,
        output frame_done,
        output read_value,
        output request_dropped
    );

    modport sink (
        input  valid,
        output ready,
        input  line_out,
        input  line_drive,
        input  busy_res,
        input  frame_done,
        input  read_value,
        input  request_dropped
    );

endinterface

[rtl/core/mdm_bit_gen.sv]
// ----------------------------------------------------------------------------
// MDIO frame bit generator
// Decodes the bit position of an active frame into the line level, the
// drive enable, the read sample strobe and the end of frame.
// ----------------------------------------------------------------------------
module mdm_bit_gen
    import mdm_pkg::*;
(
    input  logic [POS_W-1:0]      bit_pos,
    input  logic [PREAMBLE_W-1:0] preamble_len,
    input  logic                  is_read,
    input  logic [ADDR_W-1:0]     phy_addr,
    input  logic [ADDR_W-1:0]     reg_addr,
    input  logic [DATA_W-1:0]     write_value,
    output bit_ctl_t              ctl
);

    logic [POS_W-1:0] pre_ext;
    logic [POS_W-1:0] rel;
    logic [2:0]       addr_idx_phy;
    logic [2:0]       addr_idx_reg;
    logic [3:0]       data_idx;

    assign pre_ext      = POS_W'(preamble_len);
    assign rel          = bit_pos - pre_ext;
    assign addr_idx_phy = 3'(REL_PHY_END - rel);
    assign addr_idx_reg = 3'(REL_REG_END - rel);
    assign data_idx     = 4'(REL_DATA_END - rel);

    always_comb
    begin
        ctl            = '0;
        ctl.line_out   = 1'b1;
        ctl.line_drive = 1'b1;
        priority if (bit_pos < pre_ext)
        begin
            ctl.line_out = 1'b1;
        end
        else if (rel == REL_START0)
        begin
            ctl.line_out = 1'b0;
        end
        else if (rel == REL_START1)
        begin
            ctl.line_out = 1'b1;
        end
        else if (rel == REL_OP0)
        begin
            ctl.line_out = is_read;
        end
        else if (rel == REL_OP1)
        begin
            ctl.line_out = ~is_read;
        end
        else if (rel <= REL_PHY_END)
        begin
            ctl.line_out = phy_addr[addr_idx_phy];
        end
        else if (rel <= REL_REG_END)
        begin
            ctl.line_out = reg_addr[addr_idx_reg];
        end
        else if (rel < REL_DATA)
        begin
            // Turnaround: a write drives 1 then 0, a read hands the line over.
            ctl.line_out   = is_read ? 1'b0 : (rel == REL_TA0);
            ctl.line_drive = ~is_read;
        end
        else if (rel <= REL_DATA_END)
        begin
            ctl.line_out   = is_read ? 1'b0 : write_value[data_idx];
            ctl.line_drive = ~is_read;
            ctl.sample     = is_read;
        end
        else
        begin
            // Trailing bit: a write holds its last data bit on the line.
            ctl.line_out   = is_read ? 1'b0 : write_value[0];
            ctl.line_drive = ~is_read;
            ctl.done       = 1'b1;
        end
    end

endmodule

[rtl/core/mdio_management_master.sv]
// ----------------------------------------------------------------------------
// MDIO management master
// Clause 22 MDIO frame generator driven by request and tick items.
// ----------------------------------------------------------------------------
// A read or write request latches the PHY address, register address and
// write data and starts a frame; each following tick request stands for one
// MDC period and yields the level to put on MDIO during that period, whether
// the master drives the line, and the frame status. The frame is the
// preamble of ones (length set by the preamble_bits register, capped at 32),
// start 01, the opcode, five PHY and five register address bits MSB first,
// turnaround, sixteen data bits and one trailing bit. During a read the line
// is released and sixteen bits are sampled from line_in, MSB first; the word
// is returned with frame_done on the trailing bit. A request that arrives
// while a frame is running is dropped and flagged. Every request, tick or
// not, produces exactly one result. The block accepts one request per clock
// cycle while the result register can take it, and the result is registered
// in the output register on acceptance; the only loop is the bit counter and
// shift register update. A full result register that is not being
// taken stalls the request side. preamble_bits is written through the APB
// port at byte address 0; writes take effect at the access cycle.
// ----------------------------------------------------------------------------
module mdio_management_master
    import mdm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    mdm_req_if.sink               req,
    mdm_res_if.source             res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    // Configuration register.
    logic [PREAMBLE_W-1:0] preamble_reg;
    logic [PREAMBLE_W-1:0] preamble_len;

    // Frame state.
    logic                  active_reg,     active_next;
    logic [POS_W-1:0]      bit_pos_reg,    bit_pos_next;
    logic                  is_read_reg,    is_read_next;
    logic [ADDR_W-1:0]     held_phy_reg,   held_phy_next;
    logic [ADDR_W-1:0]     held_reg_reg,   held_reg_next;
    logic [DATA_W-1:0]     held_write_reg, held_write_next;
    logic [DATA_W-1:0]     read_shift_reg, read_shift_next;

    // Result register.
    logic                  out_valid_reg;
    logic                  line_out_reg,   line_out_next;
    logic                  line_drive_reg, line_drive_next;
    logic                  busy_reg,       busy_next;
    logic                  done_reg,       done_next;
    logic [DATA_W-1:0]     read_value_reg, read_value_next;
    logic                  dropped_reg,    dropped_next;

    logic                  accept;
    logic                  is_request;
    bit_ctl_t              ctl;
    req_type_t             req_code;

    // ------------------------------------------------------------------
    // APB configuration port. There is a single register, so every word
    // address decodes to it. pready is tied high: no wait states.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign prdata = CFG_DATA_W'(preamble_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            preamble_reg <= PREAMBLE_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            preamble_reg <= pwdata[PREAMBLE_W-1:0];
        end
    end

    // Preamble lengths above the Clause 22 maximum of 32 are clamped.
    assign preamble_len = (preamble_reg > PREAMBLE_MAX) ? PREAMBLE_MAX : preamble_reg;

    // ------------------------------------------------------------------
    // Handshake: a new request enters whenever the result register is
    // empty or its contents are being taken in the same cycle.
    // ------------------------------------------------------------------
    assign req.ready  = !out_valid_reg || res.ready;
    assign accept     = req.valid && req.ready;
    assign req_code   = req_type_t'(req.req_type);
    assign is_request = (req_code == REQ_READ) || (req_code == REQ_WRITE);

    mdm_bit_gen u_bit_gen (
        .bit_pos      (bit_pos_reg),
        .preamble_len (preamble_len),
        .is_read      (is_read_reg),
        .phy_addr     (held_phy_reg),
        .reg_addr     (held_reg_reg),
        .write_value  (held_write_reg),
        .ctl          (ctl)
    );

    // ------------------------------------------------------------------
    // Next state and result for the request on the input side.
    // ------------------------------------------------------------------
    always_comb
    begin
        active_next     = active_reg;
        bit_pos_next    = bit_pos_reg;
        is_read_next    = is_read_reg;
        held_phy_next   = held_phy_reg;
        held_reg_next   = held_reg_reg;
        held_write_next = held_write_reg;
        read_shift_next = read_shift_reg;

        line_out_next   = 1'b1;
        line_drive_next = 1'b1;
        done_next       = 1'b0;
        read_value_next = '0;
        dropped_next    = 1'b0;

        if (is_request)
        begin
            if (active_reg)
            begin
                dropped_next = 1'b1;
            end
            else
            begin
                active_next     = 1'b1;
                bit_pos_next    = '0;
                is_read_next    = (req_code == REQ_READ);
                held_phy_next   = req.phy_addr;
                held_reg_next   = req.reg_addr;
                held_write_next = req.write_value;
                read_shift_next = '0;
            end
        end
        else if (active_reg)
        begin
            // A tick (or the spare selector code) clocks out one frame bit.
            line_out_next   = ctl.line_out;
            line_drive_next = ctl.line_drive;
            done_next       = ctl.done;
            if (ctl.sample)
            begin
                read_shift_next = {read_shift_reg[DATA_W-2:0], req.line_in};
            end
            if (ctl.done)
            begin
                active_next  = 1'b0;
                bit_pos_next = '0;
                if (is_read_reg)
                begin
                    read_value_next = read_shift_reg;
                end
            end
            else
            begin
                bit_pos_next = bit_pos_reg + POS_W'(1);
            end
        end
        busy_next = active_next;
    end

    // ------------------------------------------------------------------
    // State registers, updated only on an accepted request.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            bit_pos_reg    <= '0;
            is_read_reg    <= 1'b0;
            held_phy_reg   <= '0;
            held_reg_reg   <= '0;
            held_write_reg <= '0;
            read_shift_reg <= '0;
        end
        else if (accept)
        begin
            active_reg     <= active_next;
            bit_pos_reg    <= bit_pos_next;
            is_read_reg    <= is_read_next;
            held_phy_reg   <= held_phy_next;
            held_reg_reg   <= held_reg_next;
            held_write_reg <= held_write_next;
            read_shift_reg <= read_shift_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register: valid flag under reset, payload loaded on accept.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            line_out_reg   <= line_out_next;
            line_drive_reg <= line_drive_next;
            busy_reg       <= busy_next;
            done_reg       <= done_next;
            read_value_reg <= read_value_next;
            dropped_reg    <= dropped_next;
        end
    end

    assign res.valid           = out_valid_reg;
    assign res.line_out        = line_out_reg;
    assign res.line_drive      = line_drive_reg;
    assign res.busy_res        = busy_reg;
    assign res.frame_done      = done_reg;
    assign res.read_value      = read_value_reg;
    assign res.request_dropped = dropped_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // A released line is always reported low.
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.line_drive |-> !res.line_out)
        else $error("released MDIO line reported high");

    // The frame ends on a tick, so it can neither leave the block busy
    // nor coincide with a dropped request.
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.frame_done |-> !res.busy_res && !res.request_dropped)
        else $error("frame_done with busy or dropped request");

    // The bit counter never runs past the longest possible frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        bit_pos_reg <= (POS_W'(PREAMBLE_MAX) + REL_TAIL))
        else $error("bit position beyond end of frame");

    // An idle block never holds a nonzero bit position.
    assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> (bit_pos_reg == '0))
        else $error("bit position nonzero while idle");

endmodule
